### rtl/core/assert_macros.svh
// Assertion macros for the RTL of the slot store allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, switched off while reset is high.
`define SSA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// Checked on every rising edge, reset included.
`define SSA_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: assertion failed");

`endif

### rtl/core/ssa_pkg.sv
// Package with the field widths, codes and constants of the slot store allocator.
`default_nettype none

package ssa_pkg;

  localparam int REQ_W  = 2;
  localparam int IDX_W  = 6;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 7;

  localparam logic [CFG_W-1:0] COUNT_RESET = 7'd64;

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd3;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd3;

  typedef logic [REQ_W-1:0]  req_type_t;
  typedef logic [IDX_W-1:0]  slot_idx_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [CFG_W-1:0]  cfg_t;

endpackage

`default_nettype wire

### rtl/core/ssa_if.sv
// Request and response channel interfaces of the slot store allocator.
`default_nettype none

interface ssa_req_if;
  import ssa_pkg::*;

  logic      valid;
  logic      ready;
  req_type_t req_type;
  slot_idx_t slot_index;
  data_t     item_data;

  modport source (output valid, output req_type, output slot_index, output item_data,
                  input ready);
  modport sink   (input valid, input req_type, input slot_index, input item_data,
                  output ready);
endinterface

interface ssa_rsp_if;
  import ssa_pkg::*;

  logic      valid;
  logic      ready;
  status_t   status;
  slot_idx_t assigned_slot;
  data_t     read_data;
  logic      slot_is_empty;

  modport source (output valid, output status, output assigned_slot, output read_data,
                  output slot_is_empty, input ready);
  modport sink   (input valid, input status, input assigned_slot, input read_data,
                  input slot_is_empty, output ready);
endinterface

`default_nettype wire

### rtl/core/slot_store_allocator_core.sv
// Top level of the slot store allocator: request register, decision logic and response register.
//
//   channel   dir   handshake        words
//   req       in    valid / ready    req_type, slot_index, item_data
//   rsp       out   valid / ready    status, assigned_slot, read_data, slot_is_empty
//   cfg       in    cfg_wr_en        cfg_wr_data (slot_count)
//
// A request is taken into the request register, decided there and its response is
// registered; one request per cycle is sustained while responses are taken.
// The slot data RAM is read when the request is taken; a write by the request just
// ahead of it is forwarded. Reset clears the occupancy map and sets the count to 64.
// A stalled response holds the request register, which in turn holds off new words.
`default_nettype none

module slot_store_allocator_core #(
  parameter int SLOTS      = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  ssa_req_if.sink             req,
  ssa_rsp_if.source           rsp,
  input  wire logic           cfg_wr_en,
  input  wire ssa_pkg::cfg_t  cfg_wr_data
);
  import ssa_pkg::*;

  `include "assert_macros.svh"

  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW  = 1 << SW;
  localparam int CW  = ($clog2(SLOTS + 1) > CFG_W) ? $clog2(SLOTS + 1) : CFG_W;
  localparam int XIW = (SW > IDX_W) ? SW : IDX_W;
  localparam int XDW = (ELEM_WIDTH > DATA_W) ? ELEM_WIDTH : DATA_W;

  cfg_t             slot_count;
  logic [SLOTS-1:0] occ_map;
  logic [SLOTS-1:0] occ_map_next;

  logic             s1_valid;
  req_type_t        s1_req;
  slot_idx_t        s1_idx;
  data_t            s1_data;
  logic             fwd_hit;
  logic [ELEM_WIDTH-1:0] fwd_data;

  logic             out_valid;
  status_t          out_status;
  slot_idx_t        out_slot;
  data_t            out_rdata;
  logic             out_empty;

  logic             out_free;
  logic             s1_fire;
  logic             in_fire;

  logic [CW-1:0]    cnt_raw;
  logic [CW-1:0]    cnt;
  logic [SW-1:0]    pick_slot;
  logic             pick_full;
  logic             add_ok;
  logic             in_range;
  logic [XIW-1:0]   s1_idx_x;
  logic [SW-1:0]    s1_idx_s;
  logic [XIW-1:0]   in_idx_x;
  logic [SW-1:0]    in_idx_s;
  logic [PW-1:0]    map_ext;
  logic             idx_set;
  logic [ELEM_WIDTH-1:0] ram_q;
  logic [ELEM_WIDTH-1:0] slot_word;
  logic [ELEM_WIDTH-1:0] wr_word;
  logic [XDW-1:0]   in_data_x;
  logic [XDW-1:0]   rd_data_x;
  logic [XIW-1:0]   pick_x;

  status_t          res_status;
  slot_idx_t        res_slot;
  data_t            res_rdata;
  logic             res_empty;

  assign out_free  = !out_valid || rsp.ready;
  assign s1_fire   = s1_valid && out_free;
  assign req.ready = !s1_valid || out_free;
  assign in_fire   = req.valid && req.ready;

  assign cnt_raw = CW'(slot_count);
  assign cnt     = (cnt_raw == '0) ? CW'(1) :
                   (cnt_raw > CW'(SLOTS)) ? CW'(SLOTS) : cnt_raw;

  assign s1_idx_x = XIW'(s1_idx);
  assign s1_idx_s = s1_idx_x[SW-1:0];
  assign in_idx_x = XIW'(req.slot_index);
  assign in_idx_s = in_idx_x[SW-1:0];
  assign map_ext  = PW'(occ_map);
  assign idx_set  = map_ext[s1_idx_s];
  assign in_range = CW'(s1_idx) < cnt;

  assign in_data_x = XDW'(s1_data);
  assign wr_word   = in_data_x[ELEM_WIDTH-1:0];
  assign slot_word = fwd_hit ? fwd_data : ram_q;
  assign rd_data_x = XDW'(slot_word);
  assign pick_x    = XIW'(pick_slot);

  ssa_pick #(
    .SLOTS (SLOTS),
    .CW    (CW)
  ) u_pick (
    .occ_map (occ_map),
    .cnt     (cnt),
    .slot    (pick_slot),
    .full    (pick_full)
  );

  assign add_ok = s1_valid && (s1_req == REQ_ADD) && !pick_full;

  ssa_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (s1_fire && add_ok),
    .waddr (pick_slot),
    .wdata (wr_word),
    .re    (in_fire),
    .raddr (in_idx_s),
    .rdata (ram_q)
  );

  always_comb begin
    res_status = STATUS_OK;
    res_slot   = '0;
    res_rdata  = '0;
    res_empty  = 1'b0;
    occ_map_next = occ_map;
    if (s1_req == REQ_ADD) begin
      if (pick_full) begin
        res_status = STATUS_FULL;
      end else begin
        res_slot = pick_x[IDX_W-1:0];
        occ_map_next[pick_slot] = 1'b1;
      end
    end else if (!in_range) begin
      res_status = STATUS_RANGE;
    end else begin
      unique case (s1_req)
        REQ_REMOVE: begin
          occ_map_next[s1_idx_s] = 1'b0;
        end
        REQ_READ: begin
          if (!idx_set) begin
            res_status = STATUS_EMPTY;
          end else begin
            res_rdata = rd_data_x[DATA_W-1:0];
          end
        end
        default: begin
          res_empty = !idx_set;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= COUNT_RESET;
      occ_map    <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      fwd_hit    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        slot_count <= cfg_wr_data;
        occ_map    <= '0;
      end else if (s1_fire) begin
        occ_map <= occ_map_next;
      end
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        fwd_hit <= s1_fire && add_ok && (pick_slot == in_idx_s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req   <= req.req_type;
      s1_idx   <= req.slot_index;
      s1_data  <= req.item_data;
      fwd_data <= wr_word;
    end
    if (s1_fire) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_rdata  <= res_rdata;
      out_empty  <= res_empty;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.assigned_slot = out_slot;
  assign rsp.read_data     = out_rdata;
  assign rsp.slot_is_empty = out_empty;

  `SSA_ASSERT(a_add_sets_bit, clk, rst,
    (s1_fire && add_ok && !cfg_wr_en) |=> occ_map[$past(pick_slot)])
  `SSA_ASSERT(a_fire_gives_rsp, clk, rst, s1_fire |=> out_valid)
  `SSA_ASSERT(a_stall_only_full, clk, rst, !req.ready |-> (s1_valid && out_valid))
  `SSA_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> ((occ_map == '0) && !out_valid))

endmodule

`default_nettype wire

### rtl/core/ssa_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module ssa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/ssa_pick.sv
// Slot chooser for an add: priority encoders over the occupancy map.
`default_nettype none

module ssa_pick #(
  parameter int SLOTS = 64,
  parameter int CW    = 7
) (
  input  wire logic [SLOTS-1:0]                          occ_map,
  input  wire logic [CW-1:0]                             cnt,
  output logic      [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] slot,
  output logic                                           full
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0] free_map;
  logic [SW-1:0]    lo;
  logic [SW-1:0]    hi;
  logic [SW-1:0]    free_lo;
  logic             any_set;
  logic             any_free;
  logic [CW-1:0]    hi_plus;

  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      free_map[s] = !occ_map[s] && (CW'(s) < cnt);
    end
  end

  always_comb begin
    lo      = '0;
    free_lo = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (occ_map[s]) begin
        lo = SW'(s);
      end
      if (free_map[s]) begin
        free_lo = SW'(s);
      end
    end
  end

  always_comb begin
    hi = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if (occ_map[s]) begin
        hi = SW'(s);
      end
    end
  end

  assign any_set  = |occ_map;
  assign any_free = |free_map;
  assign hi_plus  = CW'(hi) + CW'(1);

  always_comb begin
    slot = '0;
    full = 1'b0;
    priority if (!any_set) begin
      slot = '0;
    end else if (lo != '0) begin
      slot = lo - SW'(1);
    end else if (hi_plus < cnt) begin
      slot = hi + SW'(1);
    end else if (any_free) begin
      slot = free_lo;
    end else begin
      full = 1'b1;
    end
  end

endmodule

`default_nettype wire
